FILE: src/ipv4_header_generator_defines.svh
// Assertion helpers used by ipv4_header_generator; clk and rst_n must be in scope.
`ifndef IPV4_HEADER_GENERATOR_DEFINES_SVH
`define IPV4_HEADER_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IHG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IHG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ihg_pkg.sv
package ihg_pkg;

  localparam int unsigned MAX_FRAME_PAYLOAD_DEF = 1500;

  localparam logic [7:0]  VER_IHL   = 8'h45;
  localparam logic [7:0]  TTL_VALUE = 8'd64;
  localparam logic [16:0] HDR_BYTES = 17'd20;
  localparam logic [15:0] MASK16    = 16'hFFFF;

  // Order of the five header words on the result channel.
  typedef enum logic [2:0] {
    W_LEN,
    W_IDENT,
    W_TTL,
    W_SRC,
    W_DST
  } word_sel_t;

  // One request as handed to the word emitter.
  typedef struct packed {
    logic        err;
    logic [15:0] total;
    logic [15:0] ident;
    logic [7:0]  proto;
    logic [31:0] dst;
    logic [18:0] sum;   // raw sum of the header halfwords, not yet folded
  } req_t;

  function automatic logic [15:0] csum_fold(input logic [18:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
    s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
    return s2[15:0] ^ MASK16;
  endfunction

endpackage

FILE: src/ihg_req_if.sv
interface ihg_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] dst_address;
  logic [7:0]  protocol_number;
  logic [15:0] payload_length;

  modport source (output valid, output dst_address, output protocol_number,
                  output payload_length, input ready);
  modport sink   (input valid, input dst_address, input protocol_number,
                  input payload_length, output ready);
endinterface

FILE: src/ihg_res_if.sv
interface ihg_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  logic        last_word;
  logic        status;

  modport source (output valid, output header_word, output last_word,
                  output status, input ready);
  modport sink   (input valid, input header_word, input last_word,
                  input status, output ready);
endinterface

FILE: src/ihg_header_emit.sv
module ihg_header_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [31:0]   src_addr,
  input  logic          req_valid,
  output logic          req_ready,
  input  ihg_pkg::req_t req,
  ihg_res_if.source     res
);
  import ihg_pkg::*;

  logic      e_valid_r;
  req_t      e_req_r;
  word_sel_t e_idx_r;
  word_sel_t e_idx_nxt;
  logic      out_valid_r;
  logic [31:0] out_word_r;
  logic        out_last_r;
  logic        out_status_r;

  logic        load_ok;
  logic        emit;
  logic        is_last;
  logic        done;
  logic        take;
  logic [31:0] word_nxt;

  assign load_ok   = !out_valid_r || res.ready;
  assign emit      = e_valid_r && load_ok;
  assign is_last   = e_req_r.err || (e_idx_r == W_DST);
  assign done      = emit && is_last;
  assign req_ready = !e_valid_r || done;
  assign take      = req_valid && req_ready;
  assign e_idx_nxt = word_sel_t'(e_idx_r + 3'd1);

  always_comb begin
    case (e_idx_r)
      W_LEN:   word_nxt = {VER_IHL, 8'h00, e_req_r.total};
      W_IDENT: word_nxt = {e_req_r.ident, 16'h0000};
      W_TTL:   word_nxt = {TTL_VALUE, e_req_r.proto, csum_fold(e_req_r.sum)};
      W_SRC:   word_nxt = src_addr;
      W_DST:   word_nxt = e_req_r.dst;
      default: word_nxt = 32'd0;
    endcase
    // rejected request: one zero beat
    if (e_req_r.err) begin
      word_nxt = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r   <= 1'b0;
      e_idx_r     <= W_LEN;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        e_valid_r <= 1'b1;
        e_idx_r   <= W_LEN;
      end else if (done) begin
        e_valid_r <= 1'b0;
      end else if (emit) begin
        e_idx_r <= e_idx_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      e_req_r <= req;
    end
    if (emit) begin
      out_word_r   <= word_nxt;
      out_last_r   <= is_last;
      out_status_r <= e_req_r.err;
    end
  end

  assign res.valid       = out_valid_r;
  assign res.header_word = out_word_r;
  assign res.last_word   = out_last_r;
  assign res.status      = out_status_r;

endmodule

FILE: src/ipv4_header_generator.sv
// channel   dir  beat payload                                   handshake
// in_req    in   dst_address, protocol_number, payload_length   valid/ready
// out_res   out  header_word, last_word, status                 valid/ready
// cfg       in   cfg_wdata = source_address                     cfg_we
//
// A good request yields five beats, a rejected one a single beat; the output
// register moves one beat per cycle while out_res.ready is high, so rejected
// requests pass one per cycle then; a new request is taken as the last beat
// of the current one is emitted. Beats pass the hold, emit and output registers.
// rst_n is synchronous: clears the identification counter, source address and
// all valid flags. Output stalls back up through the emitter into the hold stage.
`include "ipv4_header_generator_defines.svh"

module ipv4_header_generator #(
  parameter int unsigned MAX_FRAME_PAYLOAD = ihg_pkg::MAX_FRAME_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  ihg_req_if.sink     in_req,
  ihg_res_if.source   out_res
);
  import ihg_pkg::*;

  localparam logic [16:0] MaxTotal = 17'(MAX_FRAME_PAYLOAD);

  logic [31:0] src_r;
  logic [15:0] ident_r;
  logic [15:0] ident_nxt;

  logic        a_valid_r;
  logic        a_err_r;
  logic [15:0] a_total_r;
  logic [15:0] a_ident_r;
  logic [7:0]  a_proto_r;
  logic [31:0] a_dst_r;

  logic [16:0] total17;
  logic        too_large;
  logic        in_fire;
  logic        e_ready;
  logic        a_take;
  req_t        a_req;
  logic        good_fire;
  logic        err_beat_ok;

  assign total17   = HDR_BYTES + {1'b0, in_req.payload_length};
  assign too_large = total17 > MaxTotal;
  assign a_take    = a_valid_r && e_ready;
  assign in_req.ready = !a_valid_r || a_take;
  assign in_fire   = in_req.valid && in_req.ready;
  assign ident_nxt = ident_r + 16'd1;
  assign good_fire   = in_fire && !too_large;
  assign err_beat_ok = out_res.last_word && (out_res.header_word == 32'd0);

  always_comb begin
    a_req.err   = a_err_r;
    a_req.total = a_total_r;
    a_req.ident = a_ident_r;
    a_req.proto = a_proto_r;
    a_req.dst   = a_dst_r;
    a_req.sum   = {3'd0, VER_IHL, 8'h00} + {3'd0, a_total_r} + {3'd0, a_ident_r}
                + {3'd0, TTL_VALUE, a_proto_r}
                + {3'd0, src_r[31:16]} + {3'd0, src_r[15:0]}
                + {3'd0, a_dst_r[31:16]} + {3'd0, a_dst_r[15:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r     <= 32'd0;
      ident_r   <= 16'd0;
      a_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        src_r <= cfg_wdata;
      end
      if (in_fire && !too_large) begin
        ident_r <= ident_nxt;
      end
      if (in_fire) begin
        a_valid_r <= 1'b1;
      end else if (a_take) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_err_r   <= too_large;
      a_total_r <= total17[15:0];
      a_ident_r <= ident_nxt;
      a_proto_r <= in_req.protocol_number;
      a_dst_r   <= in_req.dst_address;
    end
  end

  ihg_header_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_addr  (src_r),
    .req_valid (a_valid_r),
    .req_ready (e_ready),
    .req       (a_req),
    .res       (out_res)
  );

  `IHG_ASSERT_NEXT(a_ident_hold, !good_fire, ident_r == $past(ident_r), "stray ident update")
  `IHG_ASSERT_NEXT(a_hold_fill, in_fire, a_valid_r, "accepted request not held")
  `IHG_ASSERT_NOW(a_err_beat, out_res.valid && out_res.status, err_beat_ok, "bad error beat")

endmodule
